// ===== design/sm4_pkg.sv =====
// Shared types, constants and round functions for the SM4 block cipher.
package sm4_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int ROUND_W     = $clog2(ROUND_COUNT);
   localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUND_COUNT - 1);

   // Configuration register indexes
   localparam logic REG_KEY_UPPER = 1'b0;
   localparam logic REG_KEY_LOWER = 1'b1;

   // Request operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   // System parameter FK
   localparam logic [31:0] FK0 = 32'hA3B1BAC6;
   localparam logic [31:0] FK1 = 32'h56AA3350;
   localparam logic [31:0] FK2 = 32'h677D9197;
   localparam logic [31:0] FK3 = 32'hB27022DC;

   localparam logic [7:0] SBOX [256] = '{
      8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,
      8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
      8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,
      8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,
      8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
      8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,
      8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
      8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,
      8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
      8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,
      8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
      8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,
      8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
      8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,
      8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
      8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,
      8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
      8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,
      8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
      8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,
      8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
      8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,
      8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
      8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,
      8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
      8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,
      8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
      8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,
      8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
      8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,
      8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
   };

   // Controller to datapath commands
   typedef struct packed {
      logic               load_key;    // seed state with key ^ FK
      logic               load_block;  // capture request block and op
      logic               round_en;    // run one round on the state
      logic               expand;      // round is a key expansion round
      logic               first_read;  // fetch first round key of a new request
      logic               out_load;    // move state into result register
      logic [ROUND_W-1:0] round;       // current round index
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_full;                  // result register holds an untaken result
   } stat_type;

   // Byte-wise S-box substitution
   function automatic logic [31:0] sub_word(input logic [31:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // Linear transform L used by the data rounds
   function automatic logic [31:0] lin_data(input logic [31:0] t);
      return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
   endfunction

   // Linear transform L' used by the key rounds
   function automatic logic [31:0] lin_key(input logic [31:0] t);
      return t ^ rotl(t, 13) ^ rotl(t, 23);
   endfunction

   // CK constant: byte j of word i is (4i+j)*7 mod 256
   function automatic logic [31:0] ck_word(input logic [ROUND_W-1:0] idx);
      logic [31:0] w;
      logic [7:0]  base;
      w    = '0;
      base = 8'({idx, 2'b00});
      for (int j = 0; j < 4; j++) begin
         w = {w[23:0], 8'((base + 8'(j)) * 8'd7)};
      end
      return w;
   endfunction

endpackage

// ===== design/sm4_ctrl.sv =====
// Sequencer for key expansion, cipher rounds and result hand-off.
module sm4_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sm4_pkg::stat_type stat,
   output sm4_pkg::cmd_type  cmd
);
   import sm4_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXPAND = 4'b0010,
      ST_CRYPT  = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               keys_ready_ff, keys_ready_in;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      keys_ready_in = keys_ready_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.round     = round_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.first_read = 1'b1;
            req_tready     = keys_ready_ff;
            if (!keys_ready_ff && !csr_wr_en) begin
               cmd.load_key = 1'b1;
               round_in     = '0;
               state_in     = ST_EXPAND;
            end else if (keys_ready_ff && req_tvalid) begin
               cmd.load_block = 1'b1;
               round_in       = '0;
               state_in       = ST_CRYPT;
            end
         end
         ST_EXPAND: begin
            // a key write restarts the expansion from IDLE
            if (csr_wr_en) begin
               state_in = ST_IDLE;
            end else begin
               cmd.round_en = 1'b1;
               cmd.expand   = 1'b1;
               round_in     = ROUND_W'(round_ff + 1'b1);
               if (round_ff == ROUND_LAST) begin
                  keys_ready_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_CRYPT: begin
            cmd.round_en = 1'b1;
            round_in     = ROUND_W'(round_ff + 1'b1);
            if (round_ff == ROUND_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         keys_ready_in = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         round_ff      <= '0;
         keys_ready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         keys_ready_ff <= keys_ready_in;
      end
   end

endmodule

// ===== design/sm4_datapath.sv =====
// Key registers, round key store, shared round unit and result register.
module sm4_datapath (
   input  logic              clock,
   input  logic              reset,
   input  sm4_pkg::cmd_type  cmd,
   output sm4_pkg::stat_type stat,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [63:0]       csr_wdata,
   input  logic [127:0]      req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [127:0]      rsp_tdata
);
   import sm4_pkg::*;

   logic [63:0]        key_upper_ff, key_lower_ff;
   logic [31:0]        x_ff [4];
   logic [31:0]        x_in [4];
   logic               op_ff;
   logic [31:0]        rk_store_ff [ROUND_COUNT];
   logic [31:0]        rk_ff;
   logic [ROUND_W-1:0] rd_addr;
   logic [31:0]        mix, t, nx;
   logic               rsp_valid_ff;
   logic [127:0]       rsp_data_ff;

   // Key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_KEY_UPPER: key_upper_ff <= csr_wdata;
            REG_KEY_LOWER: key_lower_ff <= csr_wdata;
            default:       key_upper_ff <= key_upper_ff;
         endcase
      end
   end

   // Shared round unit: S-box then L or L'
   always_comb begin
      mix = x_ff[1] ^ x_ff[2] ^ x_ff[3] ^ (cmd.expand ? ck_word(cmd.round) : rk_ff);
      t   = sub_word(mix);
      nx  = x_ff[0] ^ (cmd.expand ? lin_key(t) : lin_data(t));
   end

   // State word update
   always_comb begin
      x_in = x_ff;
      if (cmd.load_key) begin
         x_in[0] = key_upper_ff[63:32] ^ FK0;
         x_in[1] = key_upper_ff[31:0]  ^ FK1;
         x_in[2] = key_lower_ff[63:32] ^ FK2;
         x_in[3] = key_lower_ff[31:0]  ^ FK3;
      end else if (cmd.load_block) begin
         x_in[0] = req_tdata[63:32];
         x_in[1] = req_tdata[31:0];
         x_in[2] = req_tdata[127:96];
         x_in[3] = req_tdata[95:64];
      end else if (cmd.round_en) begin
         x_in[0] = x_ff[1];
         x_in[1] = x_ff[2];
         x_in[2] = x_ff[3];
         x_in[3] = nx;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (cmd.load_block) begin
         op_ff <= req_tuser;
      end
   end

   // Round key for the next round is read ahead into a register; decrypt walks the store backward
   assign rd_addr = cmd.first_read ? {ROUND_W{req_tuser == OP_DECRYPT}}
                  : ROUND_W'(cmd.round + 1'b1) ^ {ROUND_W{op_ff == OP_DECRYPT}};

   always_ff @(posedge clock) begin
      if (cmd.round_en && cmd.expand) begin
         rk_store_ff[cmd.round] <= nx;
      end
      rk_ff <= rk_store_ff[rd_addr];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {x_ff[1], x_ff[0], x_ff[3], x_ff[2]};
      end
   end

   assign stat.out_full = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule

// ===== design/sm4_block_cipher.sv =====
// Top level of the SM4 block cipher engine.
// SM4 engine with a 128-bit key written through two 64-bit registers
// (index 0 holds MK0:MK1, index 1 holds MK2:MK3). Every key write starts a
// key expansion (a seed step, then the key rounds) that fills the 32-word
// round key store; no request is accepted until it finishes, and a further
// key write restarts it. A request carries the block in req_tdata and the
// operation in req_tuser (0 encrypt, 1 decrypt). Each block passes through
// an accept step, the rounds through the single shared S-box/L round unit
// reading one round key per cycle from the store, and a load of the result
// register, which waits while an untaken result is still held there. The
// next request is accepted while a result waits in that register.
module sm4_block_cipher (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [63:0]  csr_wdata,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // block_upper[63:0], block_lower[127:64]
   input  logic         req_tuser,   // op[0]
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // result_upper[63:0], result_lower[127:64]
);
   import sm4_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sm4_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sm4_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A key write invalidates the round keys before the next request
   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("request accepted right after a key write");

   // Only one block in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted while a block is in flight");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");

   // Loading a block or the key seed never coincides with a round
   a_load_excl: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_block || cmd.load_key) |-> !cmd.round_en)
      else $error("state load collides with a round");

endmodule

// ===== bench/tb_sm4_block_cipher.sv =====
// Self-checking testbench for the SM4 block cipher engine with a built-in cipher predictor.
`timescale 1ns / 1ps

module tb_sm4_block_cipher;
   import sm4_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES  = 40;     // a little more than one block's latency
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_BLOCKS   = 160;

   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
   } cipher_out_type;

   typedef enum int {
      READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_TOGGLE
   } ready_mode_type;
   typedef enum int {
      KEY_BOTH, KEY_UPPER_ONLY, KEY_LOWER_ONLY, KEY_BACK_TO_BACK
   } key_change_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_wr_en;
   logic         csr_index;
   logic [63:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;    // block_upper[63:0], block_lower[127:64]
   logic         req_tuser;    // op[0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;    // result_upper[63:0], result_lower[127:64]

   // Predictor state: key registers and expanded schedule
   logic [63:0]  key_hi = '0;
   logic [63:0]  key_lo = '0;
   logic [31:0]  round_keys [ROUND_COUNT];
   bit           schedule_valid = 1'b0;

   cipher_out_type expected_blocks [$];
   int             error_count = 0;
   int             idle_cycles = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_cycles_left = 0;

   sm4_block_cipher uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] subst_bytes(input logic [31:0] w);
      logic [31:0] r;
      for (int b = 0; b < 4; b++) r[8*b +: 8] = SBOX[w[8*b +: 8]];
      return r;
   endfunction

   function automatic logic [31:0] rol32(input logic [31:0] w, input int n);
      logic [63:0] d;
      d = {w, w} << n;
      return d[63:32];
   endfunction

   // CK: byte j of word i is (4i+j)*7, kept to 8 bits
   function automatic logic [31:0] key_round_const(input int i);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) w = {w[23:0], 8'((4 * i + j) * 7)};
      return w;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] k [4];
      logic [31:0] t;
      logic [31:0] nk;
      k[0] = key_hi[63:32] ^ FK0;
      k[1] = key_hi[31:0]  ^ FK1;
      k[2] = key_lo[63:32] ^ FK2;
      k[3] = key_lo[31:0]  ^ FK3;
      for (int i = 0; i < ROUND_COUNT; i++) begin
         t  = subst_bytes(k[1] ^ k[2] ^ k[3] ^ key_round_const(i));
         nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
         round_keys[i] = nk;
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = nk;
      end
      schedule_valid = 1'b1;
   endfunction

   function automatic cipher_out_type cipher_block(input logic op, input logic [63:0] upper,
                                                   input logic [63:0] lower);
      logic [31:0] x [4];
      logic [31:0] rk;
      logic [31:0] t;
      logic [31:0] nx;
      cipher_out_type r;
      // a request before any key write runs on the key registers as they stand
      if (!schedule_valid) expand_round_keys();
      x[0] = upper[63:32];
      x[1] = upper[31:0];
      x[2] = lower[63:32];
      x[3] = lower[31:0];
      for (int i = 0; i < ROUND_COUNT; i++) begin
         rk = (op == OP_DECRYPT) ? round_keys[ROUND_COUNT - 1 - i] : round_keys[i];
         t  = subst_bytes(x[1] ^ x[2] ^ x[3] ^ rk);
         nx = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = nx;
      end
      r.upper = {x[3], x[2]};
      r.lower = {x[1], x[0]};
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Present one request and hold it until taken; valid stays up for a following request
   task automatic send_block(input logic op, input logic [63:0] upper, input logic [63:0] lower);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {lower, upper};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      expected_blocks.push_back(cipher_block(op, upper, lower));
   endtask

   task automatic pause_requests(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Key register write; hold keeps the enable up for a write in the very next cycle
   task automatic set_key_reg(input logic idx, input logic [63:0] value, input bit hold);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == REG_KEY_UPPER) key_hi = value;
      else key_lo = value;
      expand_round_keys();
      if (!hold) begin
         @(negedge clock);
         csr_wr_en <= 1'b0;
      end
   endtask

   function automatic logic [63:0] pick_word64();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         3: return ~(64'd1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ---------------------------------------------------------------- monitors

   // Result checker
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = expected_blocks.pop_front();
            if (rsp_tdata[63:0] !== want.upper)
               report_mismatch($sformatf("result_upper %h, want %h", rsp_tdata[63:0], want.upper));
            if (rsp_tdata[127:64] !== want.lower)
               report_mismatch($sformatf("result_lower %h, want %h",
                                         rsp_tdata[127:64], want.lower));
         end
      end
   end

   // Receiver back-pressure: a mode held for a random stretch
   always @(negedge clock) begin
      if (mode_cycles_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_cycles_left = $urandom_range(50, 300);
      end else begin
         mode_cycles_left--;
      end
      unique case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
         default:      rsp_tready <= ~rsp_tready;
      endcase
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Requests before any key write use the all-zero key
   task automatic test_power_on_key();
      send_block(OP_ENCRYPT, '0, '0);
      send_block(OP_DECRYPT, '1, '1);
      drain_results();
   endtask

   // Published example key/plaintext, both directions, plus extreme blocks
   task automatic test_known_vector();
      set_key_reg(REG_KEY_UPPER, 64'h0123456789ABCDEF, 1'b1);
      set_key_reg(REG_KEY_LOWER, 64'hFEDCBA9876543210, 1'b0);
      send_block(OP_ENCRYPT, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      send_block(OP_DECRYPT, 64'h681EDF34D206965E, 64'h86B3E94F536E4246);
      send_block(OP_ENCRYPT, '1, '0);
      send_block(OP_DECRYPT, '0, '1);
      drain_results();
   endtask

   // Writing one half keeps the other half already held
   task automatic test_half_key_writes();
      set_key_reg(REG_KEY_LOWER, '1, 1'b0);
      send_block(OP_ENCRYPT, 64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A);
      send_block(OP_DECRYPT, 64'h5A5A5A5A5A5A5A5A, 64'hA5A5A5A5A5A5A5A5);
      drain_results();
      set_key_reg(REG_KEY_UPPER, '1, 1'b0);
      send_block(OP_ENCRYPT, '1, '1);
      send_block(OP_DECRYPT, '0, '0);
      drain_results();
   endtask

   // Key writes in consecutive cycles hold off the expansion until the last one
   task automatic test_key_restart();
      set_key_reg(REG_KEY_UPPER, 64'hDEADBEEF01234567, 1'b1);
      set_key_reg(REG_KEY_LOWER, 64'h89ABCDEF13579BDF, 1'b1);
      set_key_reg(REG_KEY_UPPER, 64'h0F1E2D3C4B5A6978, 1'b0);
      send_block(OP_ENCRYPT, 64'h0000000100000002, 64'h0000000300000004);
      send_block(OP_DECRYPT, 64'h8000000080000000, 64'h8000000080000000);
      drain_results();
   endtask

   // Sender stops until the engine has emptied, then resumes
   task automatic test_drain_pause();
      for (int i = 0; i < 3; i++)
         send_block(1'($urandom_range(0, 1)), pick_word64(), pick_word64());
      drain_results();
      for (int i = 0; i < 3; i++)
         send_block(1'($urandom_range(0, 1)), pick_word64(), pick_word64());
      drain_results();
   endtask

   // Keys per phase (all ones, all zeros, then random), random blocks in bursts, with random gaps in most phases
   task automatic test_random_traffic();
      key_change_type change;
      bit             no_gaps;
      int             sent;
      int             burst;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         change = key_change_type'($urandom_range(0, 3));
         if (phase == 0) begin
            set_key_reg(REG_KEY_UPPER, '1, 1'b1);
            set_key_reg(REG_KEY_LOWER, '1, 1'b0);
         end else if (phase == 1) begin
            set_key_reg(REG_KEY_UPPER, '0, 1'b0);
            set_key_reg(REG_KEY_LOWER, '0, 1'b0);
         end else begin
            unique case (change)
               KEY_UPPER_ONLY: set_key_reg(REG_KEY_UPPER, pick_word64(), 1'b0);
               KEY_LOWER_ONLY: set_key_reg(REG_KEY_LOWER, pick_word64(), 1'b0);
               KEY_BACK_TO_BACK: begin
                  set_key_reg(REG_KEY_LOWER, pick_word64(), 1'b1);
                  set_key_reg(REG_KEY_UPPER, pick_word64(), 1'b0);
               end
               default: begin
                  set_key_reg(REG_KEY_UPPER, pick_word64(), 1'b0);
                  set_key_reg(REG_KEY_LOWER, pick_word64(), 1'b0);
               end
            endcase
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_BLOCKS) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < PHASE_BLOCKS; i++) begin
               send_block(1'($urandom_range(0, 1)), pick_word64(), pick_word64());
               sent++;
            end
            if (!no_gaps && $urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 40));
         end
         drain_results();
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset      = 1'b1;
      csr_wr_en  = 1'b0;
      csr_index  = REG_KEY_UPPER;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ENCRYPT;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_key();
      test_known_vector();
      test_half_key_writes();
      test_key_restart();
      test_drain_pause();
      test_random_traffic();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_blocks.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_blocks.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
